// File: src/pct_pkg.sv
`default_nettype none
package pct_pkg;

  // number formats
  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 11;
  localparam int SCALE_W         = 23;
  localparam int SCALE_FRAC_BITS = 11;
  localparam int DEG_W           = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;

  // divider for screen to user: numerator 2*(p << frac) + s, denominator 2*s
  localparam int DIV_DEN_W = SCALE_W + 1;
  localparam int DIV_NUM_W = COORD_W + SCALE_FRAC_BITS + 1;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int QUOT_W    = DIV_NUM_W + 1;
  localparam int LANES     = 4;

  // wide working widths of the tail
  localparam int HGT_W  = COORD_W + 2;
  localparam int UDX_W  = QUOT_W + 1;
  localparam int USR_W  = UDX_W + 2;
  localparam int SDX_W  = COORD_W + 2;
  localparam int SDY_W  = COORD_W + 4;
  localparam int PROD_W = SDY_W + DIV_DEN_W;
  localparam int WIDE_W = PROD_W - SCALE_FRAC_BITS + 1;

  localparam logic signed [COORD_W-1:0] DFLT_MEDIA_W = COORD_W'(612 * (1 << COORD_FRAC_BITS));
  localparam logic signed [COORD_W-1:0] DFLT_MEDIA_H = COORD_W'(792 * (1 << COORD_FRAC_BITS));
  localparam logic [SCALE_W-1:0]        SCALE_RESET  = SCALE_W'(1 << SCALE_FRAC_BITS);
  localparam logic signed [PROD_W-1:0]  ROUND_HALF   = PROD_W'(1 << (SCALE_FRAC_BITS - 1));

  // truncating division of degrees by 90: (|deg| * DEG_RECIP) >> DEG_SHIFT
  localparam logic [DEG_W-1:0] DEG_RECIP = DEG_W'(46604);
  localparam int               DEG_SHIFT = 22;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEDIA_ONE    = 3'd0,
    REG_MEDIA_TWO    = 3'd1,
    REG_CROP_PRESENT = 3'd2,
    REG_CROP_ONE     = 3'd3,
    REG_CROP_TWO     = 3'd4,
    REG_ROTATION     = 3'd5,
    REG_ZOOM         = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_SCREEN_PT_TO_USER   = 2'd0,
    OP_USER_PT_TO_SCREEN   = 2'd1,
    OP_SCREEN_RECT_TO_USER = 2'd2,
    OP_USER_RECT_TO_SCREEN = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] t;
  } box_t;

  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x1;
  } item_t;

  typedef struct packed {
    logic [LANES-1:0][DIV_DEN_W-1:0] rem;
    logic [LANES-1:0][DIV_NUM_W-1:0] nq;
    logic [LANES-1:0]                neg;
    item_t                           item;
  } dstage_t;

  function automatic box_t norm_box(input logic [CFG_DATA_W-1:0] c1,
                                    input logic [CFG_DATA_W-1:0] c2);
    box_t o;
    logic signed [COORD_W-1:0] x1, y1, x2, y2;
    x1 = $signed(c1[COORD_W-1:0]);
    y1 = $signed(c1[CFG_DATA_W-1:COORD_W]);
    x2 = $signed(c2[COORD_W-1:0]);
    y2 = $signed(c2[CFG_DATA_W-1:COORD_W]);
    o.l = (x1 < x2) ? x1 : x2;
    o.r = (x1 < x2) ? x2 : x1;
    o.b = (y1 < y2) ? y1 : y2;
    o.t = (y1 < y2) ? y2 : y1;
    return o;
  endfunction

  function automatic logic box_empty(input box_t bx);
    return (bx.l >= bx.r) || (bx.b >= bx.t);
  endfunction

  function automatic logic is_to_user(input op_t op);
    return (op == OP_SCREEN_PT_TO_USER) || (op == OP_SCREEN_RECT_TO_USER);
  endfunction

  function automatic logic is_rect(input op_t op);
    return (op == OP_SCREEN_RECT_TO_USER) || (op == OP_USER_RECT_TO_SCREEN);
  endfunction

  // one restoring step on every lane
  function automatic dstage_t div_step(input dstage_t s, input logic [DIV_DEN_W-1:0] den);
    dstage_t o;
    logic [DIV_DEN_W:0] t;
    o = s;
    for (int i = 0; i < LANES; i++) begin
      t = {s.rem[i], s.nq[i][DIV_NUM_W-1]};
      if (t >= {1'b0, den}) begin
        o.rem[i] = DIV_DEN_W'(t - {1'b0, den});
        o.nq[i]  = {s.nq[i][DIV_NUM_W-2:0], 1'b1};
      end else begin
        o.rem[i] = t[DIV_DEN_W-1:0];
        o.nq[i]  = {s.nq[i][DIV_NUM_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: src/page_coordinate_transform_unit.sv
`default_nettype none
// page coordinate transform unit
// maps points and rectangles between screen space and page user space for one page
// cfg channel: cfg_index selects the register (media corners, crop flag, crop corners,
//   rotation, zoom), cfg_data carries the value; cfg_ready is always high. write only
//   while no transaction is in flight; an item accepted in the cycle after a write sees it
// in channel: in_tuser is the operation, in_tdata the two corners (second unused for points)
// out channel: out_tdata carries the four result coordinates, out_tuser the no-area and
//   clamp flags
// throughput: one transaction per cycle, sustained while the receiver keeps taking results
// the bulk of the pipeline is the 44-step restoring divider that divides by the zoom
//   scale, one quotient bit per stage on four lanes
// the whole pipeline moves as one: it advances whenever the output register is empty or
//   being taken, so a stalled receiver holds every stage and in_tready falls with it;
//   nothing is dropped or repeated
// reset clears all valid bits and sets the registers to their defaults (zoom 1.0, no crop,
//   empty media box which reads as 612 x 792)
module page_coordinate_transform_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  // input transactions
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // first_x, first_y, second_x, second_y
  input  wire logic [1:0]   in_tuser,   // op
  // result transactions
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // out_min_x, out_min_y, out_max_x, out_max_y
  output logic [1:0]        out_tuser   // no_visible_area, saturated
);

  localparam int CW = pct_pkg::COORD_W;

  // ---------------------------------------------------------------- config registers
  logic [63:0]                    media_one_r, media_two_r, crop_one_r, crop_two_r;
  logic                           crop_present_r;
  logic [pct_pkg::DEG_W-1:0]      rot_r;
  logic [pct_pkg::SCALE_W-1:0]    zoom_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      media_one_r    <= '0;
      media_two_r    <= '0;
      crop_present_r <= 1'b0;
      crop_one_r     <= '0;
      crop_two_r     <= '0;
      rot_r          <= '0;
      zoom_r         <= pct_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pct_pkg::REG_MEDIA_ONE:    media_one_r    <= cfg_data;
        pct_pkg::REG_MEDIA_TWO:    media_two_r    <= cfg_data;
        pct_pkg::REG_CROP_PRESENT: crop_present_r <= cfg_data[0];
        pct_pkg::REG_CROP_ONE:     crop_one_r     <= cfg_data;
        pct_pkg::REG_CROP_TWO:     crop_two_r     <= cfg_data;
        pct_pkg::REG_ROTATION:     rot_r          <= cfg_data[pct_pkg::DEG_W-1:0];
        pct_pkg::REG_ZOOM:         zoom_r         <= cfg_data[pct_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- page geometry
  // worked out from the registers in four register levels; the divider reads the effective
  // scale from level 1, the tail reads it and the last level long after any write has settled
  pct_pkg::box_t                 media_n_r, crop_n_r, media_sel_r, crop2_r, vis_sel_r, vis_r;
  logic                          crop_pres1_r, crop_use_r, crop_use3_r, none_r;
  logic                          deg_neg_r;
  logic [2*pct_pkg::DEG_W-1:0]   deg_prod_r;
  logic [1:0]                    q2_r, q3_r, q_r;
  logic [pct_pkg::SCALE_W-1:0]   sc_r;
  logic signed [pct_pkg::HGT_W-1:0] h_r;
  logic [pct_pkg::DEG_W-1:0]     deg_abs;
  logic [1:0]                    qa;
  pct_pkg::box_t                 dflt_box, clip_box;

  always_comb begin
    deg_abs    = rot_r[pct_pkg::DEG_W-1] ? (pct_pkg::DEG_W'(0) - rot_r) : rot_r;
    qa         = deg_prod_r[pct_pkg::DEG_SHIFT+1:pct_pkg::DEG_SHIFT];
    dflt_box.l = '0;
    dflt_box.b = '0;
    dflt_box.r = pct_pkg::DFLT_MEDIA_W;
    dflt_box.t = pct_pkg::DFLT_MEDIA_H;
    clip_box.l = (media_sel_r.l > crop2_r.l) ? media_sel_r.l : crop2_r.l;
    clip_box.b = (media_sel_r.b > crop2_r.b) ? media_sel_r.b : crop2_r.b;
    clip_box.r = (media_sel_r.r < crop2_r.r) ? media_sel_r.r : crop2_r.r;
    clip_box.t = (media_sel_r.t < crop2_r.t) ? media_sel_r.t : crop2_r.t;
  end

  always_ff @(posedge clk) begin
    // level 1: normalized corners, degree reciprocal product, effective scale
    media_n_r    <= pct_pkg::norm_box(media_one_r, media_two_r);
    crop_n_r     <= pct_pkg::norm_box(crop_one_r, crop_two_r);
    crop_pres1_r <= crop_present_r;
    deg_neg_r    <= rot_r[pct_pkg::DEG_W-1];
    deg_prod_r   <= {pct_pkg::DEG_W'(0), deg_abs} * {pct_pkg::DEG_W'(0), pct_pkg::DEG_RECIP};
    sc_r         <= (zoom_r == '0) ? pct_pkg::SCALE_W'(1) : zoom_r;
    // level 2: default media box, crop usable, quarter turns
    media_sel_r  <= pct_pkg::box_empty(media_n_r) ? dflt_box : media_n_r;
    crop2_r      <= crop_n_r;
    crop_use_r   <= crop_pres1_r && !pct_pkg::box_empty(crop_n_r);
    q2_r         <= deg_neg_r ? (2'd0 - qa) : qa;
    // level 3: clip crop to media
    vis_sel_r    <= crop_use_r ? clip_box : media_sel_r;
    crop_use3_r  <= crop_use_r;
    q3_r         <= q2_r;
    // level 4: emptiness and displayed height
    vis_r        <= vis_sel_r;
    none_r       <= crop_use3_r && pct_pkg::box_empty(vis_sel_r);
    q_r          <= q3_r;
    h_r          <= q3_r[0] ? (pct_pkg::HGT_W'(vis_sel_r.r) - pct_pkg::HGT_W'(vis_sel_r.l))
                            : (pct_pkg::HGT_W'(vis_sel_r.t) - pct_pkg::HGT_W'(vis_sel_r.b));
  end

  // ---------------------------------------------------------------- pipeline control
  logic en;
  logic out_vld_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // input capture
  pct_pkg::item_t in_item_r;
  logic           in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
    if (en) begin
      in_item_r <= {pct_pkg::op_t'(in_tuser), in_tdata};
    end
  end

  // ---------------------------------------------------------------- divider lanes
  // lane order x1, y1, x2, y2; floor(a / 2s) on a = 2*(p << 11) + s, done on ~a for a negative a
  // (one's complement trick) so the quotient of a negative a is the complement
  pct_pkg::dstage_t               ds_r [0:pct_pkg::DIV_STEPS];
  logic [pct_pkg::DIV_STEPS:0]    dv_r;
  pct_pkg::dstage_t               prep;
  logic [pct_pkg::DIV_DEN_W-1:0]  den;
  logic [pct_pkg::LANES-1:0][CW-1:0] lane_in;

  always_comb begin
    logic signed [pct_pkg::QUOT_W-1:0] a;
    den        = {sc_r, 1'b0};
    lane_in[0] = in_item_r.x1;
    lane_in[1] = in_item_r.y1;
    lane_in[2] = in_item_r.x2;
    lane_in[3] = in_item_r.y2;
    prep.item  = in_item_r;
    for (int i = 0; i < pct_pkg::LANES; i++) begin
      a = $signed({lane_in[i][CW-1], lane_in[i], (pct_pkg::SCALE_FRAC_BITS + 1)'(0)})
          + $signed({(pct_pkg::QUOT_W - pct_pkg::SCALE_W)'(0), sc_r});
      prep.neg[i] = a[pct_pkg::QUOT_W-1];
      prep.nq[i]  = a[pct_pkg::QUOT_W-1] ? ~a[pct_pkg::DIV_NUM_W-1:0]
                                         : a[pct_pkg::DIV_NUM_W-1:0];
      prep.rem[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[pct_pkg::DIV_STEPS-1:0], in_vld_r};
    end
    if (en) begin
      ds_r[0] <= prep;
      for (int k = 1; k <= pct_pkg::DIV_STEPS; k++) begin
        ds_r[k] <= pct_pkg::div_step(ds_r[k-1], den);
      end
    end
  end

  // ---------------------------------------------------------------- tail
  // t1: signed quotients and screen-side offsets; t2: rotation onto the box, h - dy;
  // t3: scale multiply; t4: rounding and path select; t5: clamp; then output register
  localparam int NP = 2;

  logic        t1_vld_r, t2_vld_r, t3_vld_r, t4_vld_r, t5_vld_r;
  pct_pkg::op_t t1_op_r, t2_op_r, t3_op_r, t4_op_r, t5_op_r;

  logic signed [pct_pkg::UDX_W-1:0]  t1_udx_r [NP], t1_udy_r [NP];
  logic signed [pct_pkg::SDX_W-1:0]  t1_sdx_r [NP], t1_sdy_r [NP];
  logic signed [pct_pkg::USR_W-1:0]  t2_ux_r [NP], t2_uy_r [NP];
  logic signed [pct_pkg::SDX_W-1:0]  t2_sdx_r [NP];
  logic signed [pct_pkg::SDY_W-1:0]  t2_sdyh_r [NP];
  logic signed [pct_pkg::USR_W-1:0]  t3_ux_r [NP], t3_uy_r [NP];
  logic signed [pct_pkg::PROD_W-1:0] t3_px_r [NP], t3_py_r [NP];
  logic signed [pct_pkg::WIDE_W-1:0] t4_v_r [2*NP];
  logic signed [CW-1:0]              t5_c_r [2*NP];
  logic [2*NP-1:0]                   t5_s_r;

  logic signed [pct_pkg::UDX_W-1:0]  t1_udx_nxt [NP], t1_udy_nxt [NP];
  logic signed [pct_pkg::SDX_W-1:0]  t1_sdx_nxt [NP], t1_sdy_nxt [NP];
  logic signed [pct_pkg::USR_W-1:0]  t2_ux_nxt [NP], t2_uy_nxt [NP];
  logic signed [pct_pkg::SDY_W-1:0]  t2_sdyh_nxt [NP];
  logic signed [pct_pkg::PROD_W-1:0] t3_px_nxt [NP], t3_py_nxt [NP];
  logic signed [pct_pkg::WIDE_W-1:0] t4_v_nxt [2*NP];
  logic signed [CW-1:0]              t5_c_nxt [2*NP];
  logic [2*NP-1:0]                   t5_s_nxt;

  pct_pkg::dstage_t ds_last;
  assign ds_last = ds_r[pct_pkg::DIV_STEPS];

  always_comb begin
    logic signed [pct_pkg::QUOT_W-1:0] qx, qy;
    logic signed [pct_pkg::SDX_W-1:0]  px, py, bl, bb, br, bt;
    logic signed [pct_pkg::USR_W-1:0]  dx, dy, ul, ub, ur, ut;
    logic signed [pct_pkg::PROD_W-1:0] scw, rp;
    logic signed [pct_pkg::WIDE_W-1:0] v;
    bl  = pct_pkg::SDX_W'(vis_r.l);
    bb  = pct_pkg::SDX_W'(vis_r.b);
    br  = pct_pkg::SDX_W'(vis_r.r);
    bt  = pct_pkg::SDX_W'(vis_r.t);
    ul  = pct_pkg::USR_W'(vis_r.l);
    ub  = pct_pkg::USR_W'(vis_r.b);
    ur  = pct_pkg::USR_W'(vis_r.r);
    ut  = pct_pkg::USR_W'(vis_r.t);
    scw = $signed({(pct_pkg::PROD_W - pct_pkg::SCALE_W)'(0), sc_r});
    for (int p = 0; p < NP; p++) begin
      // t1
      qx = ds_last.neg[2*p]   ? $signed(~{1'b0, ds_last.nq[2*p]})
                              : $signed({1'b0, ds_last.nq[2*p]});
      qy = ds_last.neg[2*p+1] ? $signed(~{1'b0, ds_last.nq[2*p+1]})
                              : $signed({1'b0, ds_last.nq[2*p+1]});
      t1_udx_nxt[p] = pct_pkg::UDX_W'(qx);
      t1_udy_nxt[p] = pct_pkg::UDX_W'(h_r) - pct_pkg::UDX_W'(qy);
      px = (p == 0) ? pct_pkg::SDX_W'(ds_last.item.x1) : pct_pkg::SDX_W'(ds_last.item.x2);
      py = (p == 0) ? pct_pkg::SDX_W'(ds_last.item.y1) : pct_pkg::SDX_W'(ds_last.item.y2);
      case (q_r)
        2'd1: begin
          t1_sdx_nxt[p] = py - bb;
          t1_sdy_nxt[p] = br - px;
        end
        2'd2: begin
          t1_sdx_nxt[p] = br - px;
          t1_sdy_nxt[p] = bt - py;
        end
        2'd3: begin
          t1_sdx_nxt[p] = bt - py;
          t1_sdy_nxt[p] = px - bl;
        end
        default: begin
          t1_sdx_nxt[p] = px - bl;
          t1_sdy_nxt[p] = py - bb;
        end
      endcase
      // t2
      dx = pct_pkg::USR_W'(t1_udx_r[p]);
      dy = pct_pkg::USR_W'(t1_udy_r[p]);
      case (q_r)
        2'd1: begin
          t2_ux_nxt[p] = ur - dy;
          t2_uy_nxt[p] = ub + dx;
        end
        2'd2: begin
          t2_ux_nxt[p] = ur - dx;
          t2_uy_nxt[p] = ut - dy;
        end
        2'd3: begin
          t2_ux_nxt[p] = ul + dy;
          t2_uy_nxt[p] = ut - dx;
        end
        default: begin
          t2_ux_nxt[p] = ul + dx;
          t2_uy_nxt[p] = ub + dy;
        end
      endcase
      t2_sdyh_nxt[p] = pct_pkg::SDY_W'(h_r) - pct_pkg::SDY_W'(t1_sdy_r[p]);
      // t3
      t3_px_nxt[p] = pct_pkg::PROD_W'(t2_sdx_r[p]) * scw;
      t3_py_nxt[p] = pct_pkg::PROD_W'(t2_sdyh_r[p]) * scw;
    end
    // t4
    for (int i = 0; i < 2*NP; i++) begin
      rp = (i[0] ? t3_py_r[i/2] : t3_px_r[i/2]) + pct_pkg::ROUND_HALF;
      if (pct_pkg::is_to_user(t3_op_r)) begin
        t4_v_nxt[i] = pct_pkg::WIDE_W'(i[0] ? t3_uy_r[i/2] : t3_ux_r[i/2]);
      end else begin
        t4_v_nxt[i] = pct_pkg::WIDE_W'($signed(rp[pct_pkg::PROD_W-1:pct_pkg::SCALE_FRAC_BITS]));
      end
    end
    // t5
    for (int i = 0; i < 2*NP; i++) begin
      v = t4_v_r[i];
      if (v > pct_pkg::SAT_HI) begin
        t5_c_nxt[i] = CW'(pct_pkg::SAT_HI);
        t5_s_nxt[i] = 1'b1;
      end else if (v < pct_pkg::SAT_LO) begin
        t5_c_nxt[i] = CW'(pct_pkg::SAT_LO);
        t5_s_nxt[i] = 1'b1;
      end else begin
        t5_c_nxt[i] = v[CW-1:0];
        t5_s_nxt[i] = 1'b0;
      end
    end
  end

  // output formatting: rectangle normalized, point leaves the high corner at zero
  logic [127:0] out_data_nxt;
  logic [1:0]   out_user_nxt;

  always_comb begin
    logic signed [CW-1:0] mnx, mny, mxx, mxy;
    logic                 sat;
    if (pct_pkg::is_rect(t5_op_r)) begin
      mnx = (t5_c_r[0] < t5_c_r[2]) ? t5_c_r[0] : t5_c_r[2];
      mxx = (t5_c_r[0] < t5_c_r[2]) ? t5_c_r[2] : t5_c_r[0];
      mny = (t5_c_r[1] < t5_c_r[3]) ? t5_c_r[1] : t5_c_r[3];
      mxy = (t5_c_r[1] < t5_c_r[3]) ? t5_c_r[3] : t5_c_r[1];
      sat = |t5_s_r;
    end else begin
      mnx = t5_c_r[0];
      mny = t5_c_r[1];
      mxx = '0;
      mxy = '0;
      sat = t5_s_r[0] | t5_s_r[1];
    end
    if (none_r) begin
      out_data_nxt = '0;
      out_user_nxt = 2'b01;
    end else begin
      out_data_nxt = {mxy, mxx, mny, mnx};
      out_user_nxt = {sat, 1'b0};
    end
  end

  logic [127:0] out_data_r;
  logic [1:0]   out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r  <= 1'b0;
      t2_vld_r  <= 1'b0;
      t3_vld_r  <= 1'b0;
      t4_vld_r  <= 1'b0;
      t5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r  <= dv_r[pct_pkg::DIV_STEPS];
      t2_vld_r  <= t1_vld_r;
      t3_vld_r  <= t2_vld_r;
      t4_vld_r  <= t3_vld_r;
      t5_vld_r  <= t4_vld_r;
      out_vld_r <= t5_vld_r;
    end
    if (en) begin
      t1_op_r <= ds_last.item.op;
      t2_op_r <= t1_op_r;
      t3_op_r <= t2_op_r;
      t4_op_r <= t3_op_r;
      t5_op_r <= t4_op_r;
      for (int p = 0; p < NP; p++) begin
        t1_udx_r[p]  <= t1_udx_nxt[p];
        t1_udy_r[p]  <= t1_udy_nxt[p];
        t1_sdx_r[p]  <= t1_sdx_nxt[p];
        t1_sdy_r[p]  <= t1_sdy_nxt[p];
        t2_ux_r[p]   <= t2_ux_nxt[p];
        t2_uy_r[p]   <= t2_uy_nxt[p];
        t2_sdx_r[p]  <= t1_sdx_r[p];
        t2_sdyh_r[p] <= t2_sdyh_nxt[p];
        t3_ux_r[p]   <= t2_ux_r[p];
        t3_uy_r[p]   <= t2_uy_r[p];
        t3_px_r[p]   <= t3_px_nxt[p];
        t3_py_r[p]   <= t3_py_nxt[p];
      end
      for (int i = 0; i < 2*NP; i++) begin
        t4_v_r[i] <= t4_v_nxt[i];
        t5_c_r[i] <= t5_c_nxt[i];
      end
      t5_s_r     <= t5_s_nxt;
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// File: src/pct_checker.sv
`default_nettype none
module pct_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the whole pipeline stalls together with the output register
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // no visible area gives zero coordinates and no clamp
  a_no_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("empty page result not cleared");

  // nothing leaves the block straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind page_coordinate_transform_unit pct_checker u_pct_checker (.*);
`default_nettype wire
